FILE: rtl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared types and constants for the streaming MurmurHash2 block.
// ----------------------------------------------------------------------------
package mhs_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'd97;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // What the back end does with one item
   typedef enum logic [3:0] {
      OP_BLOCK = 4'b0001,   // full word, mixed as a block
      OP_TAIL  = 4'b0010,   // last word with one to three bytes
      OP_SHORT = 4'b0100,   // short word that is not last: flag only
      OP_NONE  = 4'b1000    // empty last word: finalize only
   } mhs_op_type;

   typedef struct packed {
      mhs_op_type  op;
      logic [31:0] key;      // mixed block, masked tail bytes or raw word
      logic        first;
      logic [31:0] length;
      logic        last;
   } mhs_item_type;

endpackage

FILE: rtl/mhs_req_if.sv
// ----------------------------------------------------------------------------
// mhs_req_if
// Input word channel: valid/ready handshake with one message word.
// ----------------------------------------------------------------------------
interface mhs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        first_word;
   logic [31:0] message_length;
   logic        last_word;

   modport source (
      output valid, data_word, valid_bytes, first_word, message_length, last_word,
      input  ready
   );
   modport sink (
      input  valid, data_word, valid_bytes, first_word, message_length, last_word,
      output ready
   );
endinterface

FILE: rtl/mhs_rsp_if.sv
// ----------------------------------------------------------------------------
// mhs_rsp_if
// Result channel: valid/ready handshake with one finished hash.
// ----------------------------------------------------------------------------
interface mhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   logic        framing_error;

   modport source (
      output valid, hash_value, framing_error,
      input  ready
   );
   modport sink (
      input  valid, hash_value, framing_error,
      output ready
   );
endinterface

FILE: rtl/murmur2_hash_stream.sv
// ----------------------------------------------------------------------------
// murmur2_hash_stream
// Streaming 32-bit MurmurHash2 over messages of little-endian words.
// ----------------------------------------------------------------------------
// Usage: words arrive on req with valid/ready; first_word loads the hash with
// seed XOR message_length, last_word closes the message. Words with fewer
// than four bytes belong only on the last transfer; a short earlier word sets
// framing_error for that message. Each message gives one transfer on rsp.
// csr_wr_en/csr_wr_data write the seed; write it only while the block is idle.
// Throughput: one word per cycle while rsp accepts results; after each
// message's last word the back end also pauses for the final avalanche.
// After the last word's transfer the result passes two pre-mix stages, the
// queue, the hash update and the avalanche into the output register behind rsp.
// A stalled rsp holds its result; the four-entry queue and two front stages
// keep taking words until they fill, then req.ready drops.
// Reset clears valid flags, queue pointers and hash state, sets the seed to 97.
// ----------------------------------------------------------------------------
module murmur2_hash_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   mhs_req_if.sink     req,
   mhs_rsp_if.source   rsp
);

   logic [31:0]           seed_ff, seed_in;
   logic                  push, queue_full, pop, head_valid;
   mhs_pkg::mhs_item_type push_item, head_item;

   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mhs_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mhs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   mhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mhs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

FILE: rtl/mhs_front.sv
// ----------------------------------------------------------------------------
// mhs_front
// Accepts words, classifies them and pre-mixes full blocks in two stages.
// ----------------------------------------------------------------------------
module mhs_front (
   input  logic                  clock,
   input  logic                  reset,
   mhs_req_if.sink               req,
   output logic                  push,
   output mhs_pkg::mhs_item_type push_item,
   input  logic                  queue_full
);

   logic                  s1_valid_ff, s1_valid_in;
   mhs_pkg::mhs_item_type s1_ff, s1_in;
   logic                  s2_valid_ff, s2_valid_in;
   mhs_pkg::mhs_item_type s2_ff, s2_in;
   logic                  s1_adv, s2_adv;
   logic [31:0]           tail_mask;
   logic [31:0]           k1;

   assign s2_adv    = !s2_valid_ff || !queue_full;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req.ready = s1_adv;
   assign push      = s2_valid_ff && !queue_full;
   assign push_item = s2_ff;

   always_comb begin
      case (req.valid_bytes[1:0])
         2'd1:    tail_mask = 32'h0000_00ff;
         2'd2:    tail_mask = 32'h0000_ffff;
         2'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'h0000_0000;
      endcase
   end

   // stage 1: classify, first multiply of a block
   always_comb begin
      s1_in        = s1_ff;
      s1_valid_in  = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in  = req.valid;
         s1_in.first  = req.first_word;
         s1_in.length = req.message_length;
         s1_in.last   = req.last_word;
         // counts of five to seven behave as four
         if (req.valid_bytes[2]) begin
            s1_in.op  = mhs_pkg::OP_BLOCK;
            s1_in.key = req.data_word * mhs_pkg::MIX_MUL;
         end else if (!req.last_word) begin
            s1_in.op  = mhs_pkg::OP_SHORT;
            s1_in.key = req.data_word;
         end else if (req.valid_bytes[1:0] != 2'd0) begin
            s1_in.op  = mhs_pkg::OP_TAIL;
            s1_in.key = req.data_word & tail_mask;
         end else begin
            s1_in.op  = mhs_pkg::OP_NONE;
            s1_in.key = req.data_word;
         end
      end
   end

   // stage 2: xor-shift and second multiply of a block
   assign k1 = s1_ff.key ^ (s1_ff.key >> mhs_pkg::MIX_SHIFT);

   always_comb begin
      s2_in       = s2_ff;
      s2_valid_in = s2_valid_ff;
      if (s2_adv) begin
         s2_valid_in = s1_valid_ff;
         s2_in       = s1_ff;
         if (s1_ff.op == mhs_pkg::OP_BLOCK) begin
            s2_in.key = k1 * mhs_pkg::MIX_MUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   // a stalled stage 2 item must not change or vanish
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && queue_full |=> s2_valid_ff && $stable(s2_ff))
      else $error("front stage 2 lost a stalled item");

endmodule

FILE: rtl/mhs_queue.sv
// ----------------------------------------------------------------------------
// mhs_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module mhs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mhs_pkg::mhs_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output mhs_pkg::mhs_item_type head_item
);

   mhs_pkg::mhs_item_type             entry_ff [mhs_pkg::QUEUE_DEPTH];
   logic [mhs_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mhs_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mhs_pkg::QUEUE_CW-1:0]      count_ff, count_in;

   assign full       = (count_ff == mhs_pkg::QUEUE_CW'(mhs_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("item written into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("item read from an empty queue");

endmodule

FILE: rtl/mhs_back.sv
// ----------------------------------------------------------------------------
// mhs_back
// Folds queued items into the running hash and finalizes each message.
// ----------------------------------------------------------------------------
module mhs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           seed,
   input  logic                  head_valid,
   input  mhs_pkg::mhs_item_type head_item,
   output logic                  pop,
   mhs_rsp_if.source             rsp
);

   logic [31:0] hash_ff, hash_in;
   logic        error_ff, error_in;
   logic        fin_pend_ff, fin_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic        rsp_err_ff, rsp_err_in;

   logic [31:0] h0, mul_a, prod, hash_new;
   logic [31:0] f1, f2;
   logic        fin_go;

   // the back end waits while a finished message sits in the finalize step
   assign pop = head_valid && !fin_pend_ff;

   assign h0    = head_item.first ? (seed ^ head_item.length) : hash_ff;
   assign mul_a = (head_item.op == mhs_pkg::OP_BLOCK) ? h0 : (h0 ^ head_item.key);
   assign prod  = mul_a * mhs_pkg::MIX_MUL;

   always_comb begin
      case (head_item.op)
         mhs_pkg::OP_BLOCK: hash_new = prod ^ head_item.key;
         mhs_pkg::OP_TAIL:  hash_new = prod;
         default:           hash_new = h0;
      endcase
   end

   always_comb begin
      hash_in     = hash_ff;
      error_in    = error_ff;
      fin_pend_in = fin_pend_ff;
      if (pop) begin
         hash_in     = hash_new;
         error_in    = (error_ff && !head_item.first) || (head_item.op == mhs_pkg::OP_SHORT);
         fin_pend_in = head_item.last;
      end else if (fin_go) begin
         fin_pend_in = 1'b0;
      end
   end

   // avalanche from the stored hash, result straight into the output register
   assign f1     = hash_ff ^ (hash_ff >> mhs_pkg::FIN_SHIFT_A);
   assign f2     = f1 * mhs_pkg::MIX_MUL;
   assign fin_go = fin_pend_ff && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_err_in   = rsp_err_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = f2 ^ (f2 >> mhs_pkg::FIN_SHIFT_B);
         rsp_err_in   = error_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hash_value    = rsp_hash_ff;
   assign rsp.framing_error = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         error_ff     <= 1'b0;
         fin_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         error_ff     <= error_in;
         fin_pend_ff  <= fin_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hash_ff <= rsp_hash_in;
      rsp_err_ff  <= rsp_err_in;
   end

   a_last_finalizes: assert property (@(posedge clock) disable iff (reset)
      pop && head_item.last |=> fin_pend_ff)
      else $error("last item did not start finalization");

   a_fin_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      fin_pend_ff |-> !pop)
      else $error("item consumed while a hash waits for finalization");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for murmur2_hash_stream. Messages of little-endian
// words go in over req; a hash tracker follows every input transfer, keeps
// its own running hash and short-word flag, and queues the finished digest
// of each closed message. Every rsp transfer is compared against the oldest
// queued digest. Seeds are rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned LONG_HOLD      = 90;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned DRAIN_CYCLES   = 12;

   typedef struct packed {
      logic [31:0] hash;
      logic        framing;
   } digest_type;

   // Follows the block's hash state and queues one digest per closed message
   class hash_tracker;
      logic [31:0] seed;
      logic [31:0] hash_acc;
      logic        short_seen;
      digest_type  pending_digests[$];
      int unsigned mismatches;

      function new();
         seed       = mhs_pkg::SEED_RESET;
         hash_acc   = '0;
         short_seen = 1'b0;
         mismatches = 0;
      endfunction

      function logic [31:0] mix_word(logic [31:0] h, logic [31:0] k);
         logic [31:0] m;
         logic [31:0] hm;
         m  = k * mhs_pkg::MIX_MUL;
         m  = m ^ (m >> mhs_pkg::MIX_SHIFT);
         m  = m * mhs_pkg::MIX_MUL;
         hm = h * mhs_pkg::MIX_MUL;
         return hm ^ m;
      endfunction

      function logic [31:0] avalanche(logic [31:0] h);
         logic [31:0] x;
         x = h ^ (h >> mhs_pkg::FIN_SHIFT_A);
         x = x * mhs_pkg::MIX_MUL;
         return x ^ (x >> mhs_pkg::FIN_SHIFT_B);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endfunction

      function void note_word(logic [31:0] word, logic [2:0] nbytes, logic first,
                              logic [31:0] len, logic last);
         int unsigned n;
         digest_type  d;
         n = (nbytes > 3'd4) ? 4 : int'(nbytes);
         if (first) begin
            hash_acc   = seed ^ len;
            short_seen = 1'b0;
         end
         if (n == 4) begin
            hash_acc = mix_word(hash_acc, word);
         end else if (!last) begin
            short_seen = 1'b1;
         end else if (n != 0) begin
            hash_acc = hash_acc ^ (word & ((32'h1 << (8 * n)) - 32'h1));
            hash_acc = hash_acc * mhs_pkg::MIX_MUL;
         end
         if (last) begin
            d.hash    = avalanche(hash_acc);
            d.framing = short_seen;
            pending_digests.push_back(d);
         end
      endfunction

      function void check_result(logic [31:0] hash, logic framing);
         digest_type d;
         if (pending_digests.size() == 0) begin
            report($sformatf("unexpected result hash=%08h framing_error=%0b", hash, framing));
            return;
         end
         d = pending_digests.pop_front();
         if (hash !== d.hash || framing !== d.framing)
            report($sformatf("hash exp=%08h act=%08h framing_error exp=%0b act=%0b",
                             d.hash, hash, d.framing, framing));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   mhs_req_if req_ch ();
   mhs_rsp_if rsp_ch ();

   murmur2_hash_stream dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source)
   );

   hash_tracker tracker;
   int unsigned words_sent;
   int unsigned send_gap_pct;
   int unsigned recv_gap_pct;
   bit          long_hold_req;
   int unsigned quiet_cycles;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Result side: ready changes at the falling edge, stalls come in bursts
   initial begin : rsp_sink
      int unsigned stall_left;
      bit          hold_taken;
      stall_left    = 0;
      hold_taken    = 1'b0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (recv_gap_pct > 0 && $urandom_range(0, 99) < recv_gap_pct) begin
            stall_left   = $urandom_range(0, 14);
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         tracker.check_result(rsp_ch.hash_value, rsp_ch.framing_error);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                   (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one word at the falling edge and returns after its transfer
   task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic first, input logic [31:0] len, input logic last);
      if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_ch.data_word      = word;
      req_ch.valid_bytes    = nbytes;
      req_ch.first_word     = first;
      req_ch.message_length = len;
      req_ch.last_word      = last;
      req_ch.valid          = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.note_word(word, nbytes, first, len, last);
      words_sent++;
      @(negedge clock);
   endtask

   // Mostly well-formed messages; some carry a bad length, an oversized or
   // short word, no first marker, or are a lone word with random fields
   task automatic send_message();
      int unsigned nwords;
      int unsigned tail;
      int unsigned kind;
      int unsigned short_at;
      logic [31:0] len;
      logic [2:0]  nb;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   $urandom, 1'($urandom_range(0, 1)));
         return;
      end
      nwords   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      tail     = $urandom_range(0, 4);
      len      = (nwords - 1) * 4 + tail;
      if (kind < 12)
         len = $urandom;
      short_at = (kind >= 90 && nwords > 1) ? $urandom_range(0, nwords - 2) : nwords;
      for (int unsigned i = 0; i < nwords; i++) begin
         nb = 3'd4;
         if (i == nwords - 1)
            nb = (kind >= 12 && kind < 18) ? 3'($urandom_range(5, 7)) : 3'(tail);
         else if (i == short_at)
            nb = 3'($urandom_range(0, 3));
         else if ($urandom_range(0, 19) == 0)
            nb = 3'($urandom_range(4, 7));
         send_word($urandom, nb, (i == 0) && !(kind >= 18 && kind < 23), len,
                   i == nwords - 1);
      end
   endtask

   task automatic random_messages(input int unsigned count);
      int unsigned target;
      target = words_sent + count;
      while (words_sent < target)
         send_message();
   endtask

   // Seed may only change with the pipeline empty
   task automatic write_seed(input logic [31:0] value);
      req_ch.valid = 1'b0;
      while (tracker.pending_digests.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en    = 1'b1;
      csr_wr_data  = value;
      tracker.seed = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic directed_checks();
      send_word(32'h0000_0000, 3'd0, 1'b1, 32'd0,         1'b1);  // empty message
      send_word(32'hffff_ffff, 3'd4, 1'b1, 32'd4,         1'b1);
      send_word(32'hffff_ffff, 3'd1, 1'b1, 32'd1,         1'b1);  // tails of 1..3 bytes
      send_word(32'h1234_5678, 3'd2, 1'b1, 32'hffff_ffff, 1'b1);
      send_word(32'hdead_beef, 3'd3, 1'b1, 32'd3,         1'b1);
      send_word(32'h0000_0000, 3'd4, 1'b1, 32'd7,         1'b0);
      send_word(32'hffff_ffff, 3'd3, 1'b0, 32'd7,         1'b1);
      send_word(32'h89ab_cdef, 3'd7, 1'b1, 32'd8,         1'b0);  // oversized counts
      send_word(32'h0123_4567, 3'd5, 1'b0, 32'd8,         1'b1);
      send_word(32'hcafe_f00d, 3'd6, 1'b1, 32'd4,         1'b1);
      send_word(32'h1111_1111, 3'd2, 1'b1, 32'd12,        1'b0);  // short words mid-message
      send_word(32'h2222_2222, 3'd0, 1'b0, 32'd12,        1'b0);
      send_word(32'h3333_3333, 3'd4, 1'b0, 32'd12,        1'b1);
      send_word(32'h4444_4444, 3'd4, 1'b1, 32'd4,         1'b1);  // flag cleared again
      send_word(32'h5555_5555, 3'd4, 1'b1, 32'h8000_0000, 1'b1);  // length disagrees
      send_word(32'h6666_6666, 3'd4, 1'b0, 32'hffff_ffff, 1'b0);  // no first marker
      send_word(32'h7777_7777, 3'd2, 1'b0, 32'd0,         1'b1);
      send_word(32'h0000_0000, 3'd0, 1'b0, 32'd0,         1'b1);
      send_word(32'hffff_ffff, 3'd1, 1'b0, 32'd0,         1'b0);
      send_word(32'h0000_0000, 3'd4, 1'b0, 32'd0,         1'b1);
      send_word(32'h8888_8888, 3'd4, 1'b1, 32'd4,         1'b0);  // restart mid-message
      send_word(32'h9999_9999, 3'd4, 1'b1, 32'd8,         1'b1);
   endtask

   initial begin : stimulus
      tracker               = new();
      words_sent            = 0;
      send_gap_pct          = 0;
      recv_gap_pct          = 0;
      long_hold_req         = 1'b0;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_ch.valid          = 1'b0;
      req_ch.data_word      = '0;
      req_ch.valid_bytes    = '0;
      req_ch.first_word     = 1'b0;
      req_ch.message_length = '0;
      req_ch.last_word      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_checks();

      send_gap_pct = 20;
      recv_gap_pct = 20;
      write_seed(32'h0000_0000);
      random_messages(130);

      send_gap_pct = 35;
      recv_gap_pct = 10;
      write_seed(32'hffff_ffff);
      random_messages(130);

      // Long result stall with back-to-back short messages fills the pipe
      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_seed($urandom);
      long_hold_req = 1'b1;
      for (int i = 0; i < 12; i++) begin
         send_word($urandom, 3'd4, 1'b1, 32'd8, 1'b0);
         send_word($urandom, 3'($urandom_range(0, 4)), 1'b0, 32'd8, 1'b1);
      end
      send_gap_pct = 10;
      recv_gap_pct = 35;
      random_messages(130);

      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_seed(mhs_pkg::MIX_MUL);
      random_messages(140);
      req_ch.valid = 1'b0;

      while (tracker.pending_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending_digests.size() != 0)
         $display("%0d expected hashes never came out", tracker.pending_digests.size());
      if (tracker.mismatches == 0 && tracker.pending_digests.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mhs_pkg.sv
rtl/mhs_req_if.sv
rtl/mhs_rsp_if.sv
rtl/mhs_front.sv
rtl/mhs_queue.sv
rtl/mhs_back.sv
rtl/murmur2_hash_stream.sv
tb/sv/tb_top.sv
